@@ hw/rtl/html_escape_bounded_writer_defines.svh @@
// Assertion macros shared by the HTML escape writer RTL.
`ifndef HTML_ESCAPE_BOUNDED_WRITER_DEFINES_SVH
`define HTML_ESCAPE_BOUNDED_WRITER_DEFINES_SVH

// Checked on every edge outside reset.
`define HEBW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define HEBW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hebw_pkg.sv @@
// Shared types, character codes and entity tables for the HTML escape writer.
`timescale 1ns / 1ps

package hebw_pkg;

  // Widths of the buffer position and of the run counters.
  localparam int PosW = 16;
  localparam int RunW = 3;

  // Characters that expand to an entity, and the letters used in entities.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_GREAT = 8'h3E;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Reset value of the capacity register.
  localparam logic [PosW-1:0] CAP_RESET = 16'd4096;

  // Which run is written for the current item.
  typedef enum logic [2:0] {
    ENT_SINGLE,
    ENT_AMP,
    ENT_LESS,
    ENT_GREATER,
    ENT_APOS,
    ENT_QUOT
  } ent_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic decide;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic emit_ready;
    logic final_byte;
  } ctrl_status_t;

  // Byte at offset idx of the selected run; a single run is the input byte.
  function automatic logic [7:0] ent_char(ent_sel_t sel, logic [RunW-1:0] idx,
                                          logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    case (sel)
      ENT_AMP: begin
        case (idx)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_A;
          3'd2:    r = CH_M;
          3'd3:    r = CH_P;
          default: r = CH_SEMI;
        endcase
      end
      ENT_LESS: begin
        case (idx)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_L;
          3'd2:    r = CH_T;
          default: r = CH_SEMI;
        endcase
      end
      ENT_GREATER: begin
        case (idx)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_G;
          3'd2:    r = CH_T;
          default: r = CH_SEMI;
        endcase
      end
      ENT_APOS: begin
        case (idx)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_A;
          3'd2:    r = CH_P;
          3'd3:    r = CH_O;
          3'd4:    r = CH_S;
          default: r = CH_SEMI;
        endcase
      end
      ENT_QUOT: begin
        case (idx)
          3'd0:    r = CH_AMP;
          3'd1:    r = CH_Q;
          3'd2:    r = CH_U;
          3'd3:    r = CH_O;
          3'd4:    r = CH_T;
          default: r = CH_SEMI;
        endcase
      end
      default: r = ch;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/hebw_datapath.sv @@
// Datapath: item registers, fit test, position and abort state, output register.
`timescale 1ns / 1ps
`include "html_escape_bounded_writer_defines.svh"

module hebw_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  hebw_pkg::ctrl_cmd_t      cmd,
  output hebw_pkg::ctrl_status_t   status,
  input  logic                     cap_we,
  input  logic [15:0]              cap_wdata,
  input  logic                     kind,
  input  logic [7:0]               text_byte,
  input  logic                     last_of_string,
  output logic                     dst_valid,
  input  logic                     dst_stall,
  output logic [7:0]               out_byte,
  output logic [15:0]              out_position,
  output logic                     run_last
);
  import hebw_pkg::*;

  logic [PosW-1:0] capacity;
  logic [PosW-1:0] write_position;
  logic            string_aborted;
  logic            item_kind;
  logic [7:0]      item_byte;
  logic            item_last;
  ent_sel_t        run_sel;
  logic [RunW-1:0] run_len;
  logic [RunW-1:0] idx;
  ent_sel_t        sel_dec;
  logic [RunW-1:0] len_dec;
  logic            fits;

  // Decode the held item into a run; an aborted escaped string gives no run.
  always_comb begin
    sel_dec = ENT_SINGLE;
    len_dec = 3'd1;
    if (!item_kind && string_aborted) begin
      len_dec = 3'd0;
    end else if (!item_kind) begin
      case (item_byte)
        CH_AMP: begin
          sel_dec = ENT_AMP;
          len_dec = 3'd5;
        end
        CH_LESS: begin
          sel_dec = ENT_LESS;
          len_dec = 3'd4;
        end
        CH_GREAT: begin
          sel_dec = ENT_GREATER;
          len_dec = 3'd4;
        end
        CH_APOS: begin
          sel_dec = ENT_APOS;
          len_dec = 3'd6;
        end
        CH_QUOT: begin
          sel_dec = ENT_QUOT;
          len_dec = 3'd6;
        end
        default: begin
          sel_dec = ENT_SINGLE;
          len_dec = 3'd1;
        end
      endcase
    end
  end

  // The whole run must fit; the sum is one bit wider so it cannot wrap.
  assign fits = ({1'b0, write_position} + {{(PosW + 1 - RunW){1'b0}}, len_dec})
                <= {1'b0, capacity};

  // Status toward the controller.
  assign status.go         = (len_dec != '0) && fits;
  assign status.emit_ready = !dst_valid || !dst_stall;
  assign status.final_byte = (idx == run_len - 3'd1);

  // Control state: capacity, position, abort flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAP_RESET;
      write_position <= '0;
      string_aborted <= 1'b0;
      dst_valid      <= 1'b0;
    end else begin
      if (cap_we) begin
        capacity <= cap_wdata;
      end
      if (cmd.decide) begin
        if (item_last) begin
          string_aborted <= 1'b0;
        end else if (!item_kind && !string_aborted && !fits) begin
          string_aborted <= 1'b1;
        end
      end
      if (cmd.emit) begin
        write_position <= write_position + 16'd1;
        dst_valid      <= 1'b1;
      end else if (dst_valid && !dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  // Payload registers: held item, run selection and the output beat.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= kind;
      item_byte <= text_byte;
      item_last <= last_of_string;
    end
    if (cmd.decide) begin
      run_sel <= sel_dec;
      run_len <= len_dec;
      idx     <= '0;
    end
    if (cmd.emit) begin
      out_byte     <= ent_char(run_sel, idx, item_byte);
      out_position <= write_position;
      run_last     <= status.final_byte;
      idx          <= idx + 3'd1;
    end
  end

  // A beat is only built from inside the current run.
  `HEBW_ASSERT(a_emit_in_run, cmd.emit |-> (idx < run_len), "emit past end of run")
  // Every written beat lies inside the buffer.
  `HEBW_ASSERT(a_pos_in_buf, dst_valid |-> (out_position < capacity), "position beyond capacity")
  // Only an escaped byte can abort a string.
  `HEBW_ASSERT(a_abort_escaped, $rose(string_aborted) |-> $past(!item_kind && cmd.decide),
               "abort set without escaped decision")

endmodule

@@ hw/rtl/hebw_ctrl.sv @@
// Controller: sequences accept, decide and per-byte emit for each input beat.
`timescale 1ns / 1ps
`include "html_escape_bounded_writer_defines.svh"

module hebw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   src_valid,
  output logic                   src_stall,
  input  hebw_pkg::ctrl_status_t status,
  output hebw_pkg::ctrl_cmd_t    cmd
);
  import hebw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;

  // Input is taken only between items.
  assign src_stall = (state != S_IDLE);

  // Commands follow the state and the datapath status.
  always_comb begin
    cmd.load_item = (state == S_IDLE) && src_valid;
    cmd.decide    = (state == S_DECIDE);
    cmd.emit      = (state == S_EMIT) && status.emit_ready;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (src_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= status.go ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (status.emit_ready && status.final_byte) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted beat is always decided in the next cycle.
  `HEBW_ASSERT(a_load_then_decide, cmd.load_item |=> cmd.decide, "accept not followed by decide")
  // Reset returns the controller to accepting input.
  `HEBW_ASSERT_ALWAYS(a_reset_idle, rst |=> !src_stall, "not idle after reset")

endmodule

@@ hw/rtl/html_escape_bounded_writer.sv @@
// Top level of the bounded HTML escape writer: controller plus datapath.
//
// Input channel (src_valid / src_stall): one beat carries kind, text_byte and
// last_of_string. kind 0 escapes & < > ' " into their entities, kind 1 copies
// the byte raw. Output channel (dst_valid / dst_stall): one beat per byte
// written, with out_byte, out_position and run_last on the final byte of an
// input. A beat moves on an edge where valid is high and stall is low.
// Each input is accepted in the idle state, then its run and its fit are
// decided, then its bytes are written one per cycle while dst_stall is low;
// a dropped byte writes nothing. The rate is set by the single output
// register, which takes one byte per cycle when dst_stall is low. The first
// byte enters the output register in the emit state, after the decide state.
// A stalled receiver holds the output beat and pauses the run; src_stall
// stays high until the last byte of the run has entered the output register.
// cap_we writes the capacity register; write it only while the block is idle.
// Reset (rst, synchronous) sets capacity to 4096, clears the write position
// and the abort flag, and empties the output register.
`timescale 1ns / 1ps

module html_escape_bounded_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cap_we,
  input  logic [15:0] cap_wdata,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic        kind,
  input  logic [7:0]  text_byte,
  input  logic        last_of_string,
  output logic        dst_valid,
  input  logic        dst_stall,
  output logic [7:0]  out_byte,
  output logic [15:0] out_position,
  output logic        run_last
);
  import hebw_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer.
  hebw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  hebw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cap_we         (cap_we),
    .cap_wdata      (cap_wdata),
    .kind           (kind),
    .text_byte      (text_byte),
    .last_of_string (last_of_string),
    .dst_valid      (dst_valid),
    .dst_stall      (dst_stall),
    .out_byte       (out_byte),
    .out_position   (out_position),
    .run_last       (run_last)
  );

endmodule
